### sv/tmq_pkg.sv
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared types, field widths, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  // Field widths fixed by the item format
  localparam int SEC_W    = 32;
  localparam int NS_W     = 30;
  localparam int IN_ID_W  = 16;
  localparam int STATUS_W = 3;

  // Operation codes (input tuser)
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  // Result status codes (output tuser)
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FIRED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_DUE = 3'd4;

  // Due time; seconds in the upper bits so a plain compare orders keys
  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
  } key_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/timed_event_queue_core.sv
// ----------------------------------------------------------------------------
// Timed event queue core
// Bounded queue of timed events kept sorted by due time in a chain of cells.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH events in a chain of cells sorted by due
// time (seconds, then nanoseconds), with equal times kept in arrival order,
// so the head cell always holds the next event to fire. An add item is
// broadcast to all cells, each compares it with its own entry in parallel
// and the chain opens a gap at the right place. A run item
// checks only the head; when the current seconds reach its due seconds the
// chain shifts toward the head and the head's id is returned. Each item's
// result is written to the output register in the cycle after it is taken;
// a new item is taken in the same cycle as the previous result, so
// the sustained rate is one item per cycle while results are drained. The
// critical path is one 62-bit key compare per cell plus the shift mux. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_queue_core
  import tmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input items
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [31:0] due_seconds, [61:32] due_nanoseconds, [77:62] event_id,
  // [109:78] now_seconds, [111:110] zero
  input  wire logic [111:0] s_tdata,
  // [0] opcode
  input  wire logic [0:0]   s_tuser,
  // result items
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [15:0] fired_id
  output logic [15:0]       m_tdata,
  // [2:0] status
  output logic [2:0]        m_tuser
);

  logic               in_accept;
  logic               op;
  key_t               new_key;
  logic [ID_BITS-1:0] new_id;
  logic [SEC_W-1:0]   now_sec;

  logic               valid_vec [QUEUE_DEPTH];
  key_t               key_q     [QUEUE_DEPTH];
  logic [ID_BITS-1:0] id_q      [QUEUE_DEPTH];
  logic               place_vec [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_bits;

  logic               full;
  logic               empty;
  logic               head_due;
  cell_ctl_t          ctl;

  logic               out_valid;
  logic               out_valid_next;
  logic [STATUS_W-1:0] out_status;
  logic [STATUS_W-1:0] out_status_next;
  logic [15:0]        out_id;
  logic [15:0]        out_id_next;

  // Unpack the input item
  assign op          = s_tuser[0];
  assign new_key.sec = s_tdata[31:0];
  assign new_key.ns  = s_tdata[61:32];
  assign new_id      = ID_BITS'(s_tdata[77:62]);
  assign now_sec     = s_tdata[109:78];

  // Take an item whenever the result register is free or being emptied
  assign s_tready  = !out_valid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  // Queue status from the ends of the chain
  assign full     = valid_vec[QUEUE_DEPTH-1];
  assign empty    = !valid_vec[0];
  assign head_due = now_sec >= key_q[0].sec;

  // Broadcast command to the cells
  assign ctl.insert = in_accept && (op == OP_ADD) && !full;
  assign ctl.pop    = in_accept && (op == OP_RUN) && !empty && head_due;

  // Chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic               lv;
    key_t               lk;
    logic [ID_BITS-1:0] li;
    logic               lp;
    logic               rv;
    key_t               rk;
    logic [ID_BITS-1:0] ri;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign lk = '0;
      assign li = '0;
      assign lp = 1'b0;
    end else begin : g_mid
      assign lv = valid_vec[i-1];
      assign lk = key_q[i-1];
      assign li = id_q[i-1];
      assign lp = place_vec[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign rv = 1'b0;
      assign rk = '0;
      assign ri = '0;
    end else begin : g_body
      assign rv = valid_vec[i+1];
      assign rk = key_q[i+1];
      assign ri = id_q[i+1];
    end

    tmq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_key    (new_key),
      .new_id     (new_id),
      .left_valid (lv),
      .left_key   (lk),
      .left_id    (li),
      .left_place (lp),
      .right_valid(rv),
      .right_key  (rk),
      .right_id   (ri),
      .valid      (valid_vec[i]),
      .key        (key_q[i]),
      .id         (id_q[i]),
      .place      (place_vec[i])
    );

    assign valid_bits[i] = valid_vec[i];
  end

  // Build the result of the accepted item
  always_comb begin
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_id_next     = out_id;
    if (in_accept) begin
      out_valid_next = 1'b1;
      out_id_next    = '0;
      if (op == OP_ADD) begin
        out_status_next = full ? ST_FULL : ST_ADDED;
      end else if (empty) begin
        out_status_next = ST_EMPTY;
      end else if (head_due) begin
        out_status_next = ST_FIRED;
        out_id_next     = 16'(id_q[0]);
      end else begin
        out_status_next = ST_NOT_DUE;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_id     <= out_id_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = out_id;

  // Occupied slots always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_bits[QUEUE_DEPTH-1:1] & ~valid_bits[QUEUE_DEPTH-2:0]) == '0)
    else $error("queue has a hole in the chain");

  // Head is never later than the second entry
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    valid_vec[1] |-> !(key_q[1] < key_q[0]))
    else $error("queue head out of order");

  // A stored add grows the queue by one
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |=> $countones(valid_bits) == $past($countones(valid_bits)) + 1)
    else $error("add did not store exactly one event");

  // A fired run shrinks the queue by one
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> $countones(valid_bits) + 1 == $past($countones(valid_bits)))
    else $error("run did not remove exactly one event");

  // Fired result only follows a pop
  a_fired: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> ((out_status == ST_FIRED) == $past(ctl.pop)))
    else $error("fired status does not match queue pop");

endmodule

`default_nettype wire

### sv/tmq_cell.sv
// ----------------------------------------------------------------------------
// Timed event queue cell
// One slot of the sorted chain: holds an event, shifts toward the tail on an
// insert ahead of it, shifts toward the head on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_cell
  import tmq_pkg::*;
#(
  parameter int ID_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctl_t          ctl,
  input  wire key_t               new_key,
  input  wire logic [ID_BITS-1:0] new_id,
  // neighbor toward the head
  input  wire logic               left_valid,
  input  wire key_t               left_key,
  input  wire logic [ID_BITS-1:0] left_id,
  input  wire logic               left_place,
  // neighbor toward the tail
  input  wire logic               right_valid,
  input  wire key_t               right_key,
  input  wire logic [ID_BITS-1:0] right_id,
  // own contents
  output logic                    valid,
  output key_t                    key,
  output logic [ID_BITS-1:0]      id,
  output logic                    place
);

  logic               valid_next;
  key_t               key_next;
  logic [ID_BITS-1:0] id_next;

  // New event belongs at or before this slot: slot empty or strictly later.
  // Equal keys keep the older event ahead.
  assign place = !valid || (key > new_key);

  // Choose what this slot holds next
  always_comb begin
    valid_next = valid;
    key_next   = key;
    id_next    = id;
    if (ctl.pop) begin
      valid_next = right_valid;
      key_next   = right_key;
      id_next    = right_id;
    end else if (ctl.insert) begin
      if (left_place) begin
        valid_next = left_valid;
        key_next   = left_key;
        id_next    = left_id;
      end else if (place) begin
        valid_next = 1'b1;
        key_next   = new_key;
        id_next    = new_id;
      end
    end
  end

  // Valid flag cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    key <= key_next;
    id  <= id_next;
  end

endmodule

`default_nettype wire
